// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

    // character codes
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // sextet values at the start of each alphabet range
    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] PLUS_VALUE  = 6'd62;
    localparam logic [5:0] SLASH_VALUE = 6'd63;

    // result queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       block_end;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = '0;
        if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            s.value = 6'(c - CHAR_UPPER_A);
        end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            s.value = 6'(c - CHAR_LOWER_A + LOWER_BASE);
        end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            s.value = 6'(c - CHAR_ZERO + DIGIT_BASE);
        end else if (c == CHAR_PLUS) begin
            s.value = PLUS_VALUE;
        end else if (c == CHAR_SLASH) begin
            s.value = SLASH_VALUE;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== rtl/base64_stream_decoder_unit.sv =====
`timescale 1ns / 1ps

// base64 text decoder, one character word in, one decoded byte word out
// input channel s_*: s_char_code is one character, s_end_of_text marks the last
//   character of a text block
// output channel m_*: m_data_byte with m_byte_valid; m_block_end flags the last
//   word caused by an end-of-text character (a lone marker word with
//   m_byte_valid low when that character flushes no byte)
// whitespace and codes outside the alphabet are dropped; after '=' everything
//   is dropped until end of text
// throughput: one character per cycle while s_ready is high; a character that completes a
//   group of four pushes three bytes into an 8-entry result queue that drains
//   one word per cycle, so with m_ready held high a steady stream of characters never stalls
// decoded bytes are registered in the result queue and leave on m_* in order, behind queued words
// s_ready falls only when the queue has fewer than three free entries, which
//   happens when the receiver holds m_ready low; queued words wait, none lost
// reset (aresetn low, synchronous) empties the queue and clears held sextets,
//   the sextet count and the padding flag
module base64_stream_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic       m_block_end
);

    localparam int PW = b64d_pkg::PTR_W;

    // decoder state
    logic [1:0]  count_reg, count_next;
    logic [17:0] held_reg, held_next;
    logic        pad_reg, pad_next;

    // result queue
    b64d_pkg::result_t queue_reg [b64d_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   fill_reg, fill_next;

    // combinational decode of the presented character
    b64d_pkg::sextet_t sx;
    b64d_pkg::result_t res [b64d_pkg::MAX_RESULTS];
    logic [1:0]  n_res;
    logic        take, is_pad, sx_ok, quad;
    logic [1:0]  count_a;
    logic [17:0] held_a;
    logic [23:0] quad_word;
    logic        push, pop;

    always_comb begin
        sx     = b64d_pkg::sextet_of(s_char_code);
        take   = !pad_reg && !(s_char_code inside {b64d_pkg::CHAR_LF, b64d_pkg::CHAR_CR,
                                                   b64d_pkg::CHAR_SPACE});
        is_pad = take && s_char_code == b64d_pkg::CHAR_EQUAL;
        sx_ok  = take && !is_pad && sx.ok;
        quad   = sx_ok && count_reg == 2'd3;
        quad_word = {held_reg, sx.value};

        // state once the character itself is absorbed
        if (quad) begin
            count_a = 2'd0;
            held_a  = '0;
        end else if (sx_ok) begin
            count_a = count_reg + 2'd1;
            held_a  = {held_reg[11:0], sx.value};
        end else begin
            count_a = count_reg;
            held_a  = held_reg;
        end

        for (int i = 0; i < b64d_pkg::MAX_RESULTS; i++) begin
            res[i] = '0;
        end
        n_res = 2'd0;

        if (quad) begin
            res[0] = '{data_byte: quad_word[23:16], byte_valid: 1'b1, block_end: 1'b0};
            res[1] = '{data_byte: quad_word[15:8],  byte_valid: 1'b1, block_end: 1'b0};
            res[2] = '{data_byte: quad_word[7:0],   byte_valid: 1'b1,
                       block_end: s_end_of_text};
            n_res  = 2'd3;
        end else if (s_end_of_text) begin
            case (count_a)
                2'd2: begin
                    // two sextets flush one byte
                    res[0] = '{data_byte: held_a[11:4], byte_valid: 1'b1, block_end: 1'b1};
                    n_res  = 2'd1;
                end
                2'd3: begin
                    // three sextets flush two bytes
                    res[0] = '{data_byte: held_a[17:10], byte_valid: 1'b1, block_end: 1'b0};
                    res[1] = '{data_byte: held_a[9:2],   byte_valid: 1'b1, block_end: 1'b1};
                    n_res  = 2'd2;
                end
                default: begin
                    // nothing to flush: lone end marker
                    res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, block_end: 1'b1};
                    n_res  = 2'd1;
                end
            endcase
        end

        if (s_end_of_text) begin
            count_next = '0;
            held_next  = '0;
            pad_next   = 1'b0;
        end else begin
            count_next = count_a;
            held_next  = held_a;
            pad_next   = pad_reg | is_pad;
        end
    end

    // accept only while a full group of three still fits
    assign s_ready = fill_reg <= (PW + 1)'(b64d_pkg::QUEUE_DEPTH - b64d_pkg::MAX_RESULTS);
    assign push    = s_valid && s_ready;
    assign m_valid = fill_reg != '0;
    assign pop     = m_valid && m_ready;

    always_comb begin
        fill_next = fill_reg + (push ? (PW + 1)'(n_res) : '0) - (PW + 1)'(pop);
    end

    // state, pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            held_reg   <= '0;
            pad_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                count_reg  <= count_next;
                held_reg   <= held_next;
                pad_reg    <= pad_next;
                wr_ptr_reg <= wr_ptr_reg + PW'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fill_reg <= fill_next;
        end
    end

    // queue entries, up to three written per accepted word
    always_ff @(posedge aclk) begin
        if (push) begin
            for (int i = 0; i < b64d_pkg::MAX_RESULTS; i++) begin
                if (PW'(i) < PW'(n_res)) begin
                    queue_reg[wr_ptr_reg + PW'(i)] <= res[i];
                end
            end
        end
    end

    assign m_data_byte  = queue_reg[rd_ptr_reg].data_byte;
    assign m_byte_valid = queue_reg[rd_ptr_reg].byte_valid;
    assign m_block_end  = queue_reg[rd_ptr_reg].block_end;

endmodule

// ===== test/b64d_byte_checker.sv =====
`timescale 1ns / 1ps

module b64d_byte_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_text,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_data_byte,
    input  logic       m_byte_valid,
    input  logic       m_block_end,
    output int         fail_count,
    output int         words_due
);

    // decoded bytes still owed by the block, oldest first
    b64d_pkg::result_t bytes_due[$];

    logic [1:0]  held_count;
    logic [17:0] held_bits;
    logic        pad_seen;

    // sextet of an alphabet character, -1 for anything else
    function automatic int sextet_value(input logic [7:0] ch);
        if (ch inside {[b64d_pkg::CHAR_UPPER_A:b64d_pkg::CHAR_UPPER_Z]}) begin
            return int'(ch - b64d_pkg::CHAR_UPPER_A);
        end else if (ch inside {[b64d_pkg::CHAR_LOWER_A:b64d_pkg::CHAR_LOWER_Z]}) begin
            return int'(ch - b64d_pkg::CHAR_LOWER_A) + int'(b64d_pkg::LOWER_BASE);
        end else if (ch inside {[b64d_pkg::CHAR_ZERO:b64d_pkg::CHAR_NINE]}) begin
            return int'(ch - b64d_pkg::CHAR_ZERO) + int'(b64d_pkg::DIGIT_BASE);
        end else if (ch == b64d_pkg::CHAR_PLUS) begin
            return int'(b64d_pkg::PLUS_VALUE);
        end else if (ch == b64d_pkg::CHAR_SLASH) begin
            return int'(b64d_pkg::SLASH_VALUE);
        end
        return -1;
    endfunction

    // one accepted character: update the decode state and queue its bytes
    task automatic decode_char(input logic [7:0] ch, input logic eot);
        b64d_pkg::result_t step_words[$];
        int          v;
        logic [23:0] quad;
        if (!pad_seen && !(ch inside {b64d_pkg::CHAR_LF, b64d_pkg::CHAR_CR,
                                      b64d_pkg::CHAR_SPACE})) begin
            if (ch == b64d_pkg::CHAR_EQUAL) begin
                pad_seen = 1'b1;
            end else begin
                v = sextet_value(ch);
                if (v >= 0) begin
                    if (held_count == 2'd3) begin
                        quad = {held_bits, v[5:0]};
                        step_words.push_back('{quad[23:16], 1'b1, 1'b0});
                        step_words.push_back('{quad[15:8], 1'b1, 1'b0});
                        step_words.push_back('{quad[7:0], 1'b1, 1'b0});
                        held_bits  = '0;
                        held_count = '0;
                    end else begin
                        held_bits  = {held_bits[11:0], v[5:0]};
                        held_count = held_count + 2'd1;
                    end
                end
            end
        end
        if (eot) begin
            if (held_count == 2'd2) begin
                step_words.push_back('{held_bits[11:4], 1'b1, 1'b0});
            end else if (held_count == 2'd3) begin
                step_words.push_back('{held_bits[17:10], 1'b1, 1'b0});
                step_words.push_back('{held_bits[9:2], 1'b1, 1'b0});
            end
            if (step_words.size() == 0) begin
                step_words.push_back('{8'h00, 1'b0, 1'b1});
            end else begin
                step_words[step_words.size() - 1].block_end = 1'b1;
            end
            held_count = '0;
            held_bits  = '0;
            pad_seen   = 1'b0;
        end
        foreach (step_words[i]) bytes_due.push_back(step_words[i]);
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        b64d_pkg::result_t want;
        if (!aresetn) begin
            bytes_due.delete();
            held_count = '0;
            held_bits  = '0;
            pad_seen   = 1'b0;
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) decode_char(s_char_code, s_end_of_text);
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0h/%0b/%0b",
                             $time, m_data_byte, m_byte_valid, m_block_end);
                    fail_count++;
                end else begin
                    want = bytes_due.pop_front();
                    check_field("data_byte", want.data_byte, m_data_byte);
                    check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, m_byte_valid});
                    check_field("block_end", {7'd0, want.block_end}, {7'd0, m_block_end});
                end
            end
        end
        words_due = bytes_due.size();
    end

endmodule

// ===== test/tb_base64_stream_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_base64_stream_decoder_unit;

    localparam int RANDOM_ITEMS = 320;   // characters in the hold-off and random parts
    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int IDLE_LIMIT   = 1500;  // cycles with no word moving on either side

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code   = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_data_byte;
    logic       m_byte_valid;
    logic       m_block_end;

    int fail_count;
    int words_due;

    // both sides skip their random idling while this is set
    bit steady     = 1'b0;
    // asks the receiver for one long hold-off
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int items_counted = 0;
    int idle_cycles   = 0;

    always #10 aclk = ~aclk;

    // synchronous reset, held low at the start and never again
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    base64_stream_decoder_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_block_end   (m_block_end)
    );

    b64d_byte_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_block_end   (m_block_end),
        .fail_count    (fail_count),
        .words_due     (words_due)
    );

    // watchdog: a stuck handshake on either side ends the run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // character value of a sextet in the standard alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < b64d_pkg::LOWER_BASE[5:0]) begin
            return b64d_pkg::CHAR_UPPER_A + 8'(v);
        end else if (v < b64d_pkg::DIGIT_BASE[5:0]) begin
            return b64d_pkg::CHAR_LOWER_A + 8'(v) - b64d_pkg::LOWER_BASE;
        end else if (v < b64d_pkg::PLUS_VALUE) begin
            return b64d_pkg::CHAR_ZERO + 8'(v) - b64d_pkg::DIGIT_BASE;
        end else if (v == b64d_pkg::PLUS_VALUE) begin
            return b64d_pkg::CHAR_PLUS;
        end
        return b64d_pkg::CHAR_SLASH;
    endfunction

    // offer one character word after a random gap, return at the edge that takes it
    task automatic send_char(input logic [7:0] ch, input logic eot);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= ch;
        s_end_of_text <= eot;
        // s_ready is settled by the falling edge; high there means taken at the next rise
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_counted++;
    endtask

    task automatic send_string(input string txt, input bit eot_last);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], eot_last && i == txt.len() - 1);
        end
    endtask

    // encode random bytes as one text block, end of text on the last character;
    // the spare low bits of a short group stay random so the flush sees them
    task automatic send_text_block(input int nbytes, input bit padded);
        logic [7:0]  text[$];
        logic [7:0]  blank_chars[3] = '{b64d_pkg::CHAR_LF, b64d_pkg::CHAR_CR,
                                        b64d_pkg::CHAR_SPACE};
        logic [23:0] group;
        int          left;
        int          take;
        left = nbytes;
        while (left > 0) begin
            take  = (left >= 3) ? 3 : left;
            group = {8'($urandom), 8'($urandom), 8'($urandom)};
            text.push_back(b64_char(group[23:18]));
            text.push_back(b64_char(group[17:12]));
            if (take >= 2) begin
                text.push_back(b64_char(group[11:6]));
            end else if (padded) begin
                text.push_back(b64d_pkg::CHAR_EQUAL);
            end
            if (take == 3) begin
                text.push_back(b64_char(group[5:0]));
            end else if (padded) begin
                text.push_back(b64d_pkg::CHAR_EQUAL);
            end
            left -= take;
        end
        if (text.size() == 0) begin
            // empty block: only the end marker comes back
            send_char(blank_chars[$urandom_range(0, 2)], 1'b1);
        end else begin
            foreach (text[i]) begin
                // the odd line break or space, as wrapped text would carry
                if ($urandom_range(0, 11) == 0) send_char(blank_chars[$urandom_range(0, 2)], 1'b0);
                send_char(text[i], i == text.size() - 1);
            end
        end
    endtask

    // receiver: random stall before each word, one long hold-off on request
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall      = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
            while (!m_valid) @(negedge aclk);
            @(posedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        int n;
        int nbytes;
        bit end_it;
        wait (aresetn);
        @(posedge aclk);

        // alphabet extremes: first and last of each range, plus and slash
        send_string("A/z+", 1'b0);
        send_string("Za09", 1'b0);
        // skipped codes: line feed, carriage return, space, top bit set
        send_char(b64d_pkg::CHAR_LF, 1'b0);
        send_char(b64d_pkg::CHAR_CR, 1'b0);
        send_char(b64d_pkg::CHAR_SPACE, 1'b0);
        send_char(8'hFF, 1'b0);
        // end on a skipped character with nothing held gives the bare marker
        send_char(b64d_pkg::CHAR_LF, 1'b1);
        // character on the end step is decoded first: two sextets flush one byte
        send_string("QQ", 1'b1);
        // three sextets flush two bytes
        send_string("QQQ", 1'b1);
        // a single leftover sextet flushes nothing, marker only
        send_string("Q", 1'b1);
        // after padding everything, a second '=' too, is dropped until end
        send_string("TQ=A=", 1'b1);
        // the end character completes a quad: three bytes, last one flagged
        send_string("QUJD", 1'b1);

        // long receiver hold-off while a block streams in without gaps,
        // so the result queue fills and the input stalls
        items_counted = 0;
        steady        = 1'b1;
        hold_req      = 1'b1;
        send_text_block(48, 1'b1);
        steady        = 1'b0;

        // random part: mostly well-formed blocks, some broken ones and noise
        while (items_counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
                                                         : $urandom_range(0, 12);
                    send_text_block(nbytes, $urandom_range(0, 3) != 0);
                end
                7: begin
                    // alphabet characters with stray padding, end not always given
                    n      = $urandom_range(1, 10);
                    end_it = $urandom_range(0, 3) != 0;
                    for (int i = 0; i < n; i++) begin
                        send_char(($urandom_range(0, 5) == 0)
                                      ? b64d_pkg::CHAR_EQUAL
                                      : b64_char(6'($urandom_range(0, 63))),
                                  end_it && i == n - 1);
                    end
                end
                8: begin
                    // any code at all
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        send_char(8'($urandom_range(0, 255)),
                                  i == n - 1 && $urandom_range(0, 3) == 0);
                    end
                end
                default: begin
                    // switch between idling and back-to-back stretches
                    steady = ~steady;
                end
            endcase
        end
        // close any open block so nothing is left held
        send_char(b64d_pkg::CHAR_LF, 1'b1);
        s_valid <= 1'b0;

        // drain, then let the clock run on so a stray word is still seen
        @(negedge aclk);
        while (words_due != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/b64d_pkg.sv
rtl/base64_stream_decoder_unit.sv
test/b64d_byte_checker.sv
test/tb_base64_stream_decoder_unit.sv
